### hw/rtl/sld_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sync-length-sum deframer package
// Shared types and constants for the deframer: phase codes, status codes
// and configuration register indexes.
// ----------------------------------------------------------------------------
package sld_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned IndexW  = 9;
  localparam int unsigned StatusW = 2;
  localparam int unsigned SumW    = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] SyncFirstRst  = 8'h55;
  localparam logic [ByteW-1:0] SyncSecondRst = 8'hAA;
  localparam logic [ByteW-1:0] MaxPayloadRst = 8'd250;

  localparam logic [CfgIdxW-1:0] CfgSyncFirst  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSyncSecond = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxPayload = 2'd2;

  localparam logic [StatusW-1:0] StOk     = 2'd0;
  localparam logic [StatusW-1:0] StSumBad = 2'd1;
  localparam logic [StatusW-1:0] StTooBig = 2'd2;

  typedef enum logic [6:0] {
    PH_HUNT    = 7'b0000001,
    PH_SECOND  = 7'b0000010,
    PH_CMD     = 7'b0000100,
    PH_LEN     = 7'b0001000,
    PH_PAYLOAD = 7'b0010000,
    PH_SUM_HI  = 7'b0100000,
    PH_SUM_LO  = 7'b1000000
  } phase_t;

endpackage
`default_nettype wire

### hw/rtl/sync_length_sum_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sync-length-sum deframer
// Hunts for a two-byte sync header in a byte stream, then passes out the
// sync, command, length, payload and 16-bit checksum bytes of each frame with
// their position, and flags the final byte with a status.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one received byte per item (in_valid, in_stall,
// in_rx_byte). Each frame byte leaves on the output channel with its index,
// the command, a last flag, a status and a report request. Bytes outside a
// frame give no output item.
// A byte is captured in an input register; once the output register is free,
// the frame state is updated and the result loaded into the output register.
// Throughput is one byte per cycle while the receiver does not stall; the
// state update and the single 16-bit add per byte sit between those two registers.
// When the receiver stalls, the output register holds its item and the
// input register can still take one more byte; after that in_stall rises.
// Reset restores the sync bytes 0x55 0xAA and the length limit 250, empties
// both registers and returns the block to hunting. Configuration is written
// through cfg_we, cfg_index and cfg_wdata while the block is idle.
// ----------------------------------------------------------------------------
module sync_length_sum_deframer
  import sld_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [ByteW-1:0]   cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [ByteW-1:0]   in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [ByteW-1:0]        out_frame_byte,
  output logic [IndexW-1:0]       out_byte_index,
  output logic                    out_last,
  output logic [StatusW-1:0]      out_status,
  output logic [ByteW-1:0]        out_command,
  output logic                    out_report_request
);

  logic [ByteW-1:0] sync_first_r, sync_second_r, max_payload_r;

  logic             in_vld_r, in_vld_nxt;
  logic [ByteW-1:0] in_byte_r;

  phase_t           phase_r, phase_nxt;
  logic [ByteW-1:0] cmd_r, cmd_nxt;
  logic [ByteW-1:0] len_r, len_nxt;
  logic [ByteW-1:0] cnt_r, cnt_nxt;
  logic [SumW-1:0]  sum_r, sum_nxt;
  logic [ByteW-1:0] sum_hi_r, sum_hi_nxt;

  logic               out_vld_r, out_vld_nxt;
  logic [ByteW-1:0]   o_byte_r, o_byte_nxt;
  logic [IndexW-1:0]  o_idx_r, o_idx_nxt;
  logic               o_last_r, o_last_nxt;
  logic [StatusW-1:0] o_status_r, o_status_nxt;
  logic [ByteW-1:0]   o_cmd_r, o_cmd_nxt;
  logic               o_report_r, o_report_nxt;

  logic             out_free, proc, in_accept, has_res;
  logic [ByteW-1:0] b, cnt_inc;
  logic [SumW-1:0]  sum_add, rx_sum;

  assign out_free  = !out_vld_r || !out_stall;
  assign proc      = in_vld_r && out_free;
  assign in_stall  = in_vld_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  assign b       = in_byte_r;
  assign sum_add = sum_r + {{(SumW-ByteW){1'b0}}, b};
  assign cnt_inc = cnt_r + 8'd1;
  assign rx_sum  = {sum_hi_r, b};

  always_comb begin
    phase_nxt    = phase_r;
    cmd_nxt      = cmd_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    sum_nxt      = sum_r;
    sum_hi_nxt   = sum_hi_r;
    has_res      = 1'b0;
    o_byte_nxt   = b;
    o_idx_nxt    = '0;
    o_last_nxt   = 1'b0;
    o_status_nxt = StOk;
    o_cmd_nxt    = '0;
    o_report_nxt = 1'b0;
    unique case (phase_r)
      PH_SECOND: begin
        if (b == sync_second_r) begin
          sum_nxt   = sum_add;
          phase_nxt = PH_CMD;
          has_res   = 1'b1;
          o_idx_nxt = 9'd1;
        end else begin
          cmd_nxt    = '0;
          len_nxt    = '0;
          cnt_nxt    = '0;
          sum_hi_nxt = '0;
          if (b == sync_first_r) begin
            phase_nxt = PH_SECOND;
            sum_nxt   = {{(SumW-ByteW){1'b0}}, b};
            has_res   = 1'b1;
          end else begin
            phase_nxt = PH_HUNT;
            sum_nxt   = '0;
          end
        end
      end
      PH_CMD: begin
        cmd_nxt   = b;
        sum_nxt   = sum_add;
        phase_nxt = PH_LEN;
        has_res   = 1'b1;
        o_idx_nxt = 9'd2;
        o_cmd_nxt = b;
      end
      PH_LEN: begin
        has_res   = 1'b1;
        o_idx_nxt = 9'd3;
        o_cmd_nxt = cmd_r;
        if (b > max_payload_r) begin
          o_last_nxt   = 1'b1;
          o_status_nxt = StTooBig;
          cmd_nxt      = '0;
          len_nxt      = '0;
          cnt_nxt      = '0;
          sum_hi_nxt   = '0;
          if (cmd_r == sync_first_r && b == sync_second_r) begin
            // The rejected command and length bytes form a new sync header.
            sum_nxt   = {{(SumW-ByteW){1'b0}}, cmd_r} + {{(SumW-ByteW){1'b0}}, b};
            phase_nxt = PH_CMD;
          end else if (b == sync_first_r) begin
            sum_nxt   = {{(SumW-ByteW){1'b0}}, b};
            phase_nxt = PH_SECOND;
          end else begin
            sum_nxt   = '0;
            phase_nxt = PH_HUNT;
          end
        end else begin
          len_nxt   = b;
          cnt_nxt   = '0;
          sum_nxt   = sum_add;
          phase_nxt = (b == 8'd0) ? PH_SUM_HI : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_nxt   = sum_add;
        cnt_nxt   = cnt_inc;
        if (cnt_inc >= len_r) begin
          phase_nxt = PH_SUM_HI;
        end
        has_res   = 1'b1;
        o_idx_nxt = 9'd4 + {1'b0, cnt_r};
        o_cmd_nxt = cmd_r;
      end
      PH_SUM_HI: begin
        sum_hi_nxt = b;
        phase_nxt  = PH_SUM_LO;
        has_res    = 1'b1;
        o_idx_nxt  = 9'd4 + {1'b0, len_r};
        o_cmd_nxt  = cmd_r;
      end
      PH_SUM_LO: begin
        has_res      = 1'b1;
        o_idx_nxt    = 9'd5 + {1'b0, len_r};
        o_cmd_nxt    = cmd_r;
        o_last_nxt   = 1'b1;
        o_status_nxt = (rx_sum == sum_r) ? StOk : StSumBad;
        o_report_nxt = (rx_sum == sum_r) && (cmd_r == 8'd0);
        phase_nxt    = PH_HUNT;
        cmd_nxt      = '0;
        len_nxt      = '0;
        cnt_nxt      = '0;
        sum_nxt      = '0;
        sum_hi_nxt   = '0;
      end
      default: begin
        cmd_nxt    = '0;
        len_nxt    = '0;
        cnt_nxt    = '0;
        sum_hi_nxt = '0;
        if (b == sync_first_r) begin
          phase_nxt = PH_SECOND;
          sum_nxt   = {{(SumW-ByteW){1'b0}}, b};
          has_res   = 1'b1;
        end else begin
          phase_nxt = PH_HUNT;
          sum_nxt   = '0;
        end
      end
    endcase
  end

  always_comb begin
    if (in_accept) begin
      in_vld_nxt = 1'b1;
    end else if (proc) begin
      in_vld_nxt = 1'b0;
    end else begin
      in_vld_nxt = in_vld_r;
    end
    if (out_free) begin
      out_vld_nxt = proc && has_res;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SyncFirstRst;
      sync_second_r <= SyncSecondRst;
      max_payload_r <= MaxPayloadRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgSyncFirst:  sync_first_r  <= cfg_wdata;
        CfgSyncSecond: sync_second_r <= cfg_wdata;
        CfgMaxPayload: max_payload_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      phase_r   <= PH_HUNT;
      cmd_r     <= '0;
      len_r     <= '0;
      cnt_r     <= '0;
      sum_r     <= '0;
      sum_hi_r  <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (proc) begin
        phase_r  <= phase_nxt;
        cmd_r    <= cmd_nxt;
        len_r    <= len_nxt;
        cnt_r    <= cnt_nxt;
        sum_r    <= sum_nxt;
        sum_hi_r <= sum_hi_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r <= in_rx_byte;
    end
    if (proc && has_res) begin
      o_byte_r   <= o_byte_nxt;
      o_idx_r    <= o_idx_nxt;
      o_last_r   <= o_last_nxt;
      o_status_r <= o_status_nxt;
      o_cmd_r    <= o_cmd_nxt;
      o_report_r <= o_report_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_frame_byte     = o_byte_r;
  assign out_byte_index     = o_idx_r;
  assign out_last           = o_last_r;
  assign out_status         = o_status_r;
  assign out_command        = o_cmd_r;
  assign out_report_request = o_report_r;

`ifndef SYNTHESIS
  a_status_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !o_last_r |-> o_status_r == StOk && !o_report_r)
    else $error("status or report set on a byte that is not last");

  a_report_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && o_report_r |-> o_status_r == StOk && o_cmd_r == 8'd0)
    else $error("report request on a bad frame or nonzero command");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> o_idx_r <= 9'd260)
    else $error("byte index out of range");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_vld_r)
    else $error("input stalled while a register is free");
`endif

endmodule
`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// Sync-length-sum deframer testbench
// Drives received bytes into the deframer and checks each frame item that
// leaves it against a predictor that tracks the frame phase, the length and
// the 16-bit sum. Runs short directed sequences, random frames, broken
// headers and noise under several sync and length settings and idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  import sld_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned BytesPerStep = 215;

  typedef struct packed {
    logic [ByteW-1:0]   frame_byte;
    logic [IndexW-1:0]  byte_index;
    logic               last;
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   command;
    logic               report_request;
  } frame_item_t;

  typedef enum int {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CfgSyncFirst;
  logic [ByteW-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [ByteW-1:0]   in_rx_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ByteW-1:0]   out_frame_byte;
  logic [IndexW-1:0]  out_byte_index;
  logic               out_last;
  logic [StatusW-1:0] out_status;
  logic [ByteW-1:0]   out_command;
  logic               out_report_request;

  logic [ByteW-1:0] rx_pending[$];
  frame_item_t      expected_items[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned bytes_accepted = 0;
  int unsigned items_checked = 0;
  int unsigned frames_ok = 0;
  int unsigned frames_sum_bad = 0;
  int unsigned frames_too_big = 0;
  int unsigned report_count = 0;

  // Predictor state and its copy of the configuration registers.
  logic [ByteW-1:0] sync_first_q = SyncFirstRst;
  logic [ByteW-1:0] sync_second_q = SyncSecondRst;
  logic [ByteW-1:0] max_payload_q = MaxPayloadRst;
  phase_t           ph = PH_HUNT;
  logic [ByteW-1:0] frame_cmd = '0;
  logic [ByteW-1:0] pay_len = '0;
  logic [ByteW-1:0] payload_seen = '0;
  logic [ByteW-1:0] sum_hi_rx = '0;
  logic [SumW-1:0]  frame_sum = '0;

  sync_length_sum_deframer u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_byte    (out_frame_byte),
    .out_byte_index    (out_byte_index),
    .out_last          (out_last),
    .out_status        (out_status),
    .out_command       (out_command),
    .out_report_request(out_report_request)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic expect_item(input logic [ByteW-1:0] b, input logic [IndexW-1:0] idx,
                             input logic last, input logic [StatusW-1:0] st,
                             input logic [ByteW-1:0] cmd, input logic report);
    frame_item_t item;
    item.frame_byte = b;
    item.byte_index = idx;
    item.last = last;
    item.status = st;
    item.command = cmd;
    item.report_request = report;
    expected_items.push_back(item);
  endtask

  task automatic drop_frame();
    ph = PH_HUNT;
    frame_cmd = '0;
    pay_len = '0;
    payload_seen = '0;
    frame_sum = '0;
    sum_hi_rx = '0;
  endtask

  task automatic open_candidate(input logic [ByteW-1:0] b);
    drop_frame();
    ph = PH_SECOND;
    frame_sum = {8'h00, b};
  endtask

  task automatic deframe_byte(input logic [ByteW-1:0] b);
    logic [ByteW-1:0]  cmd;
    logic [IndexW-1:0] idx;
    logic              sum_ok;
    case (ph)
      PH_SECOND: begin
        if (b == sync_second_q) begin
          frame_sum = frame_sum + b;
          ph = PH_CMD;
          expect_item(b, 9'd1, 1'b0, StOk, 8'h00, 1'b0);
        end else if (b == sync_first_q) begin
          open_candidate(b);
          expect_item(b, 9'd0, 1'b0, StOk, 8'h00, 1'b0);
        end else begin
          drop_frame();
        end
      end
      PH_CMD: begin
        frame_cmd = b;
        frame_sum = frame_sum + b;
        ph = PH_LEN;
        expect_item(b, 9'd2, 1'b0, StOk, b, 1'b0);
      end
      PH_LEN: begin
        cmd = frame_cmd;
        if (b > max_payload_q) begin
          drop_frame();
          if (cmd == sync_first_q && b == sync_second_q) begin
            frame_sum = cmd + b;
            ph = PH_CMD;
          end else if (b == sync_first_q) begin
            open_candidate(b);
          end
          expect_item(b, 9'd3, 1'b1, StTooBig, cmd, 1'b0);
        end else begin
          pay_len = b;
          payload_seen = '0;
          frame_sum = frame_sum + b;
          ph = (b == 8'h00) ? PH_SUM_HI : PH_PAYLOAD;
          expect_item(b, 9'd3, 1'b0, StOk, cmd, 1'b0);
        end
      end
      PH_PAYLOAD: begin
        idx = 9'd4 + payload_seen;
        frame_sum = frame_sum + b;
        payload_seen = payload_seen + 8'd1;
        if (payload_seen >= pay_len) ph = PH_SUM_HI;
        expect_item(b, idx, 1'b0, StOk, frame_cmd, 1'b0);
      end
      PH_SUM_HI: begin
        sum_hi_rx = b;
        ph = PH_SUM_LO;
        expect_item(b, 9'd4 + pay_len, 1'b0, StOk, frame_cmd, 1'b0);
      end
      PH_SUM_LO: begin
        sum_ok = ({sum_hi_rx, b} == frame_sum);
        idx = 9'd5 + pay_len;
        cmd = frame_cmd;
        drop_frame();
        expect_item(b, idx, 1'b1, sum_ok ? StOk : StSumBad, cmd,
                    sum_ok && cmd == 8'h00);
      end
      default: begin
        if (b == sync_first_q) begin
          open_candidate(b);
          expect_item(b, 9'd0, 1'b0, StOk, 8'h00, 1'b0);
        end else begin
          drop_frame();
        end
      end
    endcase
  endtask

  function automatic void check_field(input string name, input logic [IndexW-1:0] want,
                                      input logic [IndexW-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : rx_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_rx_byte);
        bytes_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_rx_byte <= rx_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : frame_monitor
    frame_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_items.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected item, expected none, got byte 0x%0h index %0d",
                   $time, out_frame_byte, out_byte_index);
        end else begin
          want = expected_items.pop_front();
          items_checked++;
          check_field("frame_byte", want.frame_byte, out_frame_byte);
          check_field("byte_index", want.byte_index, out_byte_index);
          check_field("last", want.last, out_last);
          check_field("status", want.status, out_status);
          check_field("command", want.command, out_command);
          check_field("report_request", want.report_request, out_report_request);
          if (want.last) begin
            case (want.status)
              StOk:     frames_ok++;
              StSumBad: frames_sum_bad++;
              default:  frames_too_big++;
            endcase
          end
          if (want.report_request) report_count++;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d items outstanding", cycle_count,
               expected_items.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CfgSyncFirst:  sync_first_q = val;
      CfgSyncSecond: sync_second_q = val;
      CfgMaxPayload: max_payload_q = val;
      default: ;
    endcase
  endtask

  task automatic start_step(input bit write_regs, input logic [ByteW-1:0] sf,
                            input logic [ByteW-1:0] ss, input logic [ByteW-1:0] mx,
                            input gap_mode_t gaps);
    if (write_regs) begin
      write_reg(CfgSyncFirst, sf);
      write_reg(CfgSyncSecond, ss);
      write_reg(CfgMaxPayload, mx);
      @(posedge clk);
      cfg_we <= 1'b0;
    end
    @(negedge clk);
    send_idle_pct = (gaps == GAP_SEND) ? 85 : (gaps == GAP_BOTH) ? 17 : 0;
    recv_stall_pct = (gaps == GAP_RECV) ? 85 : (gaps == GAP_BOTH) ? 17 : 0;
  endtask

  task automatic queue_bytes(input logic [ByteW-1:0] bytes[]);
    foreach (bytes[i]) rx_pending.push_back(bytes[i]);
  endtask

  // Each opening ends in sync_first and sync_second; the frame sum starts from their total.
  task automatic queue_frame(input int unsigned opening);
    logic [ByteW-1:0] cmd;
    logic [ByteW-1:0] len;
    logic [ByteW-1:0] b;
    logic [SumW-1:0]  sum;
    int unsigned      r;
    rx_pending.push_back(sync_first_q);
    case (opening)
      1: begin
        rx_pending.push_back(sync_second_q);
        rx_pending.push_back(sync_first_q);
      end
      2: begin
        rx_pending.push_back(sync_second_q);
        rx_pending.push_back(8'($urandom));
        rx_pending.push_back(sync_first_q);
      end
      3: rx_pending.push_back(sync_first_q);
      default: ;
    endcase
    rx_pending.push_back(sync_second_q);
    sum = sync_first_q + sync_second_q;
    cmd = ($urandom_range(99) < 25) ? 8'h00 : 8'($urandom);
    r = $urandom_range(99);
    if (r < 12 && max_payload_q != 8'hFF) begin
      len = 8'($urandom_range(255, max_payload_q + 1));
    end else if (r < 15) begin
      len = max_payload_q;
    end else begin
      len = 8'($urandom_range((max_payload_q < 12) ? max_payload_q : 12, 0));
    end
    rx_pending.push_back(cmd);
    rx_pending.push_back(len);
    if (len > max_payload_q) return;
    sum = sum + cmd + len;
    repeat (len) begin
      r = $urandom_range(9);
      b = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
      sum = sum + b;
      rx_pending.push_back(b);
    end
    if ($urandom_range(99) < 15) sum = sum ^ 16'($urandom_range(65535, 1));
    rx_pending.push_back(sum[15:8]);
    rx_pending.push_back(sum[7:0]);
  endtask

  task automatic queue_traffic(input int unsigned n_bytes);
    int unsigned target;
    int unsigned r;
    target = rx_pending.size() + n_bytes;
    while (rx_pending.size() < target) begin
      r = $urandom_range(99);
      if (r < 60) queue_frame(0);
      else if (r < 68) queue_frame(1);
      else if (r < 74) queue_frame(2);
      else if (r < 80) queue_frame(3);
      else begin
        if ($urandom_range(2) == 0) rx_pending.push_back(sync_first_q);
        repeat ($urandom_range(6, 1)) rx_pending.push_back(8'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (rx_pending.size() != 0 || in_valid || expected_items.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  initial begin : sequencer
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    start_step(1'b0, SyncFirstRst, SyncSecondRst, MaxPayloadRst, GAP_NONE);
    queue_bytes('{8'h00, 8'hFF,
                  8'h55, 8'hAA, 8'h00, 8'h00, 8'h00, 8'hFF,
                  8'h55, 8'h55, 8'hAA, 8'h03, 8'h01, 8'hFF, 8'h12, 8'h34,
                  8'h55, 8'hAA, 8'h07, 8'hFB});
    queue_traffic(BytesPerStep);
    wait_drained();

    start_step(1'b0, SyncFirstRst, SyncSecondRst, MaxPayloadRst, GAP_SEND);
    queue_traffic(BytesPerStep);
    wait_drained();

    start_step(1'b1, 8'h00, 8'hFF, 8'h00, GAP_RECV);
    queue_traffic(BytesPerStep);
    wait_drained();

    start_step(1'b1, 8'hFF, 8'h00, 8'hFF, GAP_BOTH);
    queue_traffic(BytesPerStep);
    wait_drained();

    start_step(1'b1, 8'hF0, 8'hFE, 8'h10, GAP_NONE);
    queue_bytes('{8'hF0, 8'hFE, 8'hF0, 8'hFE, 8'h01, 8'h00, 8'h01, 8'hEF});
    queue_traffic(BytesPerStep);
    wait_drained();

    start_step(1'b1, 8'h3C, 8'h3C, 8'h08, GAP_SEND);
    queue_traffic(BytesPerStep);
    wait_drained();

    start_step(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), GAP_RECV);
    queue_traffic(BytesPerStep);
    wait_drained();

    start_step(1'b1, 8'($urandom), 8'($urandom), 8'($urandom_range(40)), GAP_BOTH);
    queue_traffic(BytesPerStep);
    wait_drained();

    start_step(1'b1, SyncFirstRst, SyncSecondRst, MaxPayloadRst, GAP_NONE);
    queue_traffic(BytesPerStep);
    wait_drained();

    $display("Sent %0d bytes over nine register settings and idle patterns; %0d items checked.",
             bytes_accepted, items_checked);
    $display("Frames ended: %0d good, %0d bad checksum, %0d oversize; %0d report requests.",
             frames_ok, frames_sum_bad, frames_too_big, report_count);
    if (mismatch_count == 0 && expected_items.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
